// File: rtl/core/b32gc_pkg.sv
// Shared types, constants and count tables for the base32 group codec.
// Used by the front, queue, back and top level modules; depends on nothing.
package b32gc_pkg;

   localparam int GROUP_W     = 40;
   localparam int COUNT_W     = 4;
   localparam int VALUE_W     = 8;
   localparam int SYM_W       = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [GROUP_W-1:0] bits;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               bad;
      logic               decode;
   } job_type;

   // Symbols produced by an encode group of c bytes: ceil(8c/5).
   function automatic logic [COUNT_W-1:0] enc_count(input logic [2:0] c);
      logic [COUNT_W-1:0] n;
      case (c)
         3'd1:    n = 4'd2;
         3'd2:    n = 4'd4;
         3'd3:    n = 4'd5;
         3'd4:    n = 4'd7;
         3'd5:    n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // Bytes produced by a decode group of r symbols: floor(5r/8), code 0 means eight.
   function automatic logic [COUNT_W-1:0] dec_count(input logic [2:0] r);
      logic [COUNT_W-1:0] n;
      case (r)
         3'd1:    n = 4'd0;
         3'd2:    n = 4'd1;
         3'd3:    n = 4'd1;
         3'd4:    n = 4'd2;
         3'd5:    n = 4'd3;
         3'd6:    n = 4'd3;
         3'd7:    n = 4'd4;
         default: n = 4'd5;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/core/base32_group_codec_top.sv
// Top level of the base32 group codec: front end, job queue and back end.
// Depends on b32gc_pkg, b32gc_front, b32gc_queue and b32gc_back.
//
// The csr channel writes decode_mode (0 encodes bytes to 5-bit symbols, 1 decodes
// symbols to bytes); csr_ready is always high, and a write clears the partial group.
// The req channel carries one byte or symbol per beat with a last flag. A beat is
// taken when req_valid is high and req_stall is low. The rsp channel returns
// symbols or bytes, one per beat, flagged with has_value, out_last and bad_symbol.
// A completed group leaves the front end as one job when its final beat is taken,
// except a decode group that holds or follows a bad symbol and is not flagged last.
// The job passes through the queue and the back end's job registers into the result
// register. The back end loads a job only while idle and then sends one beat per
// cycle unless rsp_stall holds it. req_stall rises while the job queue is full.
// When the receiver holds rsp_stall, the result register keeps its beat, the
// back end halts, the queue fills and then req_stall stops the sender.
// Reset clears the mode to encode, the partial group, the queue and the output valid flag.
module base32_group_codec_top #(
   parameter int QUEUE_DEPTH = b32gc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_decode_mode,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_value,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_value,
   output logic       rsp_has_value,
   output logic       rsp_out_last,
   output logic       rsp_bad_symbol
);
   import b32gc_pkg::*;

   logic    q_full;
   logic    q_valid;
   logic    job_push;
   logic    job_pop;
   logic    req_fire;
   job_type push_job;
   job_type head_job;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign req_fire  = req_valid && !q_full;

   b32gc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_decode_mode (csr_decode_mode),
      .req_fire        (req_fire),
      .req_in_value    (req_in_value),
      .req_in_last     (req_in_last),
      .job_push        (job_push),
      .job_data        (push_job)
   );

   b32gc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (push_job),
      .pop        (job_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (head_job)
   );

   b32gc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_valid),
      .job_data       (head_job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_has_value  (rsp_has_value),
      .rsp_out_last   (rsp_out_last),
      .rsp_bad_symbol (rsp_bad_symbol)
   );

endmodule

// File: rtl/core/b32gc_front.sv
// Front end of the base32 group codec: accepts beats, packs groups and queues jobs.
// Depends on b32gc_pkg for the job type and the count tables.
module b32gc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_decode_mode,
   input  logic                 req_fire,
   input  logic [7:0]           req_in_value,
   input  logic                 req_in_last,
   output logic                 job_push,
   output b32gc_pkg::job_type   job_data
);
   import b32gc_pkg::*;

   logic               mode_ff, mode_in;
   logic [GROUP_W-1:0] group_bits_ff, group_bits_in;
   logic [2:0]         group_count_ff, group_count_in;
   logic               error_seen_ff, error_seen_in;

   logic [GROUP_W-1:0] packed_bits;
   logic [GROUP_W-1:0] padded_bits;
   logic [2:0]         count_next;
   logic [COUNT_W-1:0] data_count;
   logic               error_next;
   logic               group_done;

   always_comb begin
      mode_in        = mode_ff;
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      error_seen_in  = error_seen_ff;
      job_push       = 1'b0;
      count_next     = group_count_ff + 3'd1;
      error_next     = error_seen_ff;
      packed_bits    = '0;
      padded_bits    = '0;
      data_count     = '0;
      group_done     = 1'b0;

      if (!mode_ff) begin
         packed_bits = {group_bits_ff[GROUP_W-9:0], req_in_value};
         group_done  = (count_next >= 3'd5) || req_in_last;
         case (count_next)
            3'd1:    padded_bits = {packed_bits[7:0], 32'd0};
            3'd2:    padded_bits = {packed_bits[15:0], 24'd0};
            3'd3:    padded_bits = {packed_bits[23:0], 16'd0};
            3'd4:    padded_bits = {packed_bits[31:0], 8'd0};
            default: padded_bits = packed_bits;
         endcase
         data_count = enc_count(count_next);
      end else begin
         error_next  = error_seen_ff | (|req_in_value[7:5]);
         packed_bits = {group_bits_ff[GROUP_W-6:0], req_in_value[4:0]};
         group_done  = (count_next == 3'd0) || req_in_last;
         case (count_next)
            3'd1:    padded_bits = {packed_bits[4:0], 35'd0};
            3'd2:    padded_bits = {packed_bits[9:0], 30'd0};
            3'd3:    padded_bits = {packed_bits[14:0], 25'd0};
            3'd4:    padded_bits = {packed_bits[19:0], 20'd0};
            3'd5:    padded_bits = {packed_bits[24:0], 15'd0};
            3'd6:    padded_bits = {packed_bits[29:0], 10'd0};
            3'd7:    padded_bits = {packed_bits[34:0], 5'd0};
            default: padded_bits = packed_bits;
         endcase
         data_count = error_next ? '0 : dec_count(count_next);
      end

      if (csr_valid) begin
         mode_in        = csr_decode_mode;
         group_bits_in  = '0;
         group_count_in = '0;
         error_seen_in  = 1'b0;
      end else if (req_fire) begin
         if (group_done) begin
            job_push       = (data_count != '0) || req_in_last;
            group_bits_in  = '0;
            group_count_in = '0;
            error_seen_in  = req_in_last ? 1'b0 : error_next;
         end else begin
            group_bits_in  = packed_bits;
            group_count_in = count_next;
            error_seen_in  = error_next;
         end
      end
   end

   always_comb begin
      job_data.bits   = padded_bits;
      job_data.count  = data_count;
      job_data.last   = req_in_last;
      job_data.bad    = error_next;
      job_data.decode = mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         error_seen_ff  <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         error_seen_ff  <= error_seen_in;
      end
   end

endmodule

// File: rtl/core/b32gc_queue.sv
// Short job queue between the front and back ends of the base32 group codec.
// Depends on b32gc_pkg for the job type.
module b32gc_queue #(
   parameter int DEPTH = b32gc_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b32gc_pkg::job_type   push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output b32gc_pkg::job_type   head_data
);
   import b32gc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Job pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("Job popped from an empty queue.");
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("Queue fill count exceeds its depth.");

endmodule

// File: rtl/core/b32gc_back.sv
// Back end of the base32 group codec: serializes queued jobs into result beats.
// Depends on b32gc_pkg for the job type and field widths.
module b32gc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  b32gc_pkg::job_type   job_data,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_value,
   output logic                 rsp_has_value,
   output logic                 rsp_out_last,
   output logic                 rsp_bad_symbol
);
   import b32gc_pkg::*;

   logic               active_ff, active_in;
   logic [GROUP_W-1:0] bits_ff, bits_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               marker_ff, marker_in;
   logic               last_ff, last_in;
   logic               bad_ff, bad_in;
   logic               decode_ff, decode_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         value_ff, value_in;
   logic               has_ff, has_in;
   logic               olast_ff, olast_in;
   logic               obad_ff, obad_in;

   logic               slot_free;
   logic               emit;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = active_ff && slot_free;
   assign job_pop   = !active_ff && job_valid;

   always_comb begin
      active_in    = active_ff;
      bits_in      = bits_ff;
      remain_in    = remain_ff;
      marker_in    = marker_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      decode_in    = decode_ff;
      rsp_valid_in = slot_free ? 1'b0 : rsp_valid_ff;
      value_in     = value_ff;
      has_in       = has_ff;
      olast_in     = olast_ff;
      obad_in      = obad_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         if (marker_ff) begin
            value_in = '0;
         end else if (decode_ff) begin
            value_in = bits_ff[GROUP_W-1 -: VALUE_W];
         end else begin
            value_in = {3'b000, bits_ff[GROUP_W-1 -: SYM_W]};
         end
         has_in   = !marker_ff;
         olast_in = last_ff && (remain_ff == 4'd1);
         obad_in  = marker_ff && bad_ff;
         bits_in  = decode_ff ? {bits_ff[GROUP_W-9:0], 8'd0} : {bits_ff[GROUP_W-6:0], 5'd0};
         remain_in = remain_ff - 4'd1;
         if (remain_ff == 4'd1) begin
            active_in = 1'b0;
         end
      end

      if (job_pop) begin
         active_in = 1'b1;
         bits_in   = job_data.bits;
         marker_in = (job_data.count == '0);
         remain_in = (job_data.count == '0) ? 4'd1 : job_data.count;
         last_in   = job_data.last;
         bad_in    = job_data.bad;
         decode_in = job_data.decode;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff   <= bits_in;
      remain_ff <= remain_in;
      marker_ff <= marker_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
      decode_ff <= decode_in;
      value_ff  <= value_in;
      has_ff    <= has_in;
      olast_ff  <= olast_in;
      obad_ff   <= obad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = value_ff;
   assign rsp_has_value  = has_ff;
   assign rsp_out_last   = olast_ff;
   assign rsp_bad_symbol = obad_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !has_ff |-> olast_ff)
      else $error("End marker beat without the last flag.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && obad_ff |-> olast_ff && !has_ff)
      else $error("Bad symbol flag on a beat other than the end marker.");
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> remain_ff != '0)
      else $error("Active job with no beats remaining.");

endmodule
